### rtl/csu_pkg.sv
// Shared types and constants for the cosine similarity unit.
package csu_pkg;

  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 48;
  localparam int NPROD_W = 2 * ACC_W;
  localparam int WIDE_W  = 128;
  localparam int SIM_W   = 16;
  localparam int R_W     = 15;
  localparam int ODD2_W  = 2 * R_W;
  localparam int RSHIFT  = 30;

  localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_NEG_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [R_W-1:0]   ONE_Q14     = R_W'(16384);

  // Operand pair loaded into the shift-add multiplier
  typedef enum logic [1:0] {
    MSEL_NORMS = 2'd0,
    MSEL_DOT   = 2'd1,
    MSEL_TRIAL = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     acc_en;
    logic     acc_clr;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     store_p;
    logic     store_r;
    logic     srch_init;
    logic     srch_prep;
    logic     srch_upd;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic zero_norm;
    logic srch_done;
  } status_t;

endpackage

### rtl/csu_dp.sv
// Datapath: accumulators, shift-add multiplier, binary search and result register.
module csu_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csu_pkg::cmd_t                     cmd,
  output csu_pkg::status_t                  status,
  input  logic signed [csu_pkg::ELEM_W-1:0] in_elem_a,
  input  logic signed [csu_pkg::ELEM_W-1:0] in_elem_b,
  output logic signed [csu_pkg::SIM_W-1:0]  out_similarity,
  output logic                              out_zero_norm
);
  import csu_pkg::*;

  logic signed [ACC_W-1:0] dot_r, dot_nxt;
  logic [ACC_W-1:0]        na_r, na_nxt, nb_r, nb_nxt;
  logic signed [PROD_W-1:0] p_ab, p_aa, p_bb;
  logic signed [ACC_W:0]   dsum;
  logic [ACC_W:0]          asum, bsum;
  logic [ACC_W-1:0]        dmag;

  logic [WIDE_W-1:0]       mcand_r, prod_r;
  logic [ACC_W-1:0]        mplier_r;
  logic [NPROD_W-1:0]      pn_r;
  logic [WIDE_W-1:0]       rhs_r;
  logic [R_W-1:0]          lo_r, hi_r, mid_r;
  logic [ODD2_W-1:0]       odd2_r;
  logic [R_W:0]            mid_sum;
  logic [R_W-1:0]          mid_c, odd_c;
  logic signed [SIM_W-1:0] sim_r;
  logic                    zero_r;

  // Element products and saturating accumulation
  always_comb begin
    p_ab = in_elem_a * in_elem_b;
    p_aa = in_elem_a * in_elem_a;
    p_bb = in_elem_b * in_elem_b;
    dsum = $signed({dot_r[ACC_W-1], dot_r}) + (ACC_W+1)'(p_ab);
    asum = {1'b0, na_r} + (ACC_W+1)'($unsigned(p_aa));
    bsum = {1'b0, nb_r} + (ACC_W+1)'($unsigned(p_bb));
    if (dsum[ACC_W] != dsum[ACC_W-1]) begin
      dot_nxt = dsum[ACC_W] ? ACC_NEG_MIN : ACC_POS_MAX;
    end else begin
      dot_nxt = dsum[ACC_W-1:0];
    end
    na_nxt = (asum[ACC_W] | asum[ACC_W-1]) ? ACC_POS_MAX : asum[ACC_W-1:0];
    nb_nxt = (bsum[ACC_W] | bsum[ACC_W-1]) ? ACC_POS_MAX : bsum[ACC_W-1:0];
    dmag   = dot_r[ACC_W-1] ? ACC_W'(-dot_r) : dot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.acc_clr) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else if (cmd.acc_en) begin
      dot_r <= dot_nxt;
      na_r  <= na_nxt;
      nb_r  <= nb_nxt;
    end
  end

  // Shift-add multiplier: one conditional add per cycle until the multiplier is spent
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod_r <= '0;
      case (cmd.mul_sel)
        MSEL_NORMS: begin
          mcand_r  <= WIDE_W'(na_r);
          mplier_r <= nb_r;
        end
        MSEL_DOT: begin
          mcand_r  <= WIDE_W'(dmag);
          mplier_r <= dmag;
        end
        MSEL_TRIAL: begin
          mcand_r  <= WIDE_W'(pn_r);
          mplier_r <= ACC_W'(odd2_r);
        end
        default: begin
          mcand_r  <= '0;
          mplier_r <= '0;
        end
      endcase
    end else if (mplier_r != '0) begin
      if (mplier_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  // Stored norm product and scaled squared dot
  always_ff @(posedge clk) begin
    if (cmd.store_p) pn_r <= prod_r[NPROD_W-1:0];
    if (cmd.store_r) rhs_r <= prod_r << RSHIFT;
  end

  // Binary search for the largest r with (2r-1)^2 * P <= D^2 * 2^30
  always_comb begin
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (R_W+1)'(1);
    mid_c   = mid_sum[R_W:1];
    odd_c   = R_W'({mid_c, 1'b0} - (R_W+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= ONE_Q14;
    end else if (cmd.srch_upd) begin
      if (prod_r <= rhs_r) lo_r <= mid_r;
      else hi_r <= mid_r - R_W'(1);
    end
    if (cmd.srch_prep) begin
      mid_r  <= mid_c;
      odd2_r <= odd_c * odd_c;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      zero_r <= status.zero_norm;
      if (status.zero_norm) sim_r <= '0;
      else if (dot_r[ACC_W-1]) sim_r <= -$signed(SIM_W'(lo_r));
      else sim_r <= $signed(SIM_W'(lo_r));
    end
  end

  assign status.mul_busy  = (mplier_r != '0);
  assign status.zero_norm = (na_r == '0) || (nb_r == '0);
  assign status.srch_done = (lo_r == hi_r);
  assign out_similarity   = sim_r;
  assign out_zero_norm    = zero_r;

endmodule

### rtl/csu_ctrl.sv
// Controller: sequences accumulation, root-free ratio search and result handoff.
module csu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last_pair,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output csu_pkg::cmd_t    cmd,
  input  csu_pkg::status_t status
);
  import csu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_WAIT_P, S_WAIT_R, S_SEARCH,
    S_START_T, S_WAIT_T, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Commands and next state
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MSEL_NORMS;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.acc_en = in_valid;
        if (in_valid && in_last_pair) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (status.zero_norm) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_NORMS;
          cmd.srch_init = 1'b1;
          state_nxt     = S_WAIT_P;
        end
      end
      S_WAIT_P: begin
        if (!status.mul_busy) begin
          cmd.store_p   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_DOT;
          state_nxt     = S_WAIT_R;
        end
      end
      S_WAIT_R: begin
        if (!status.mul_busy) begin
          cmd.store_r = 1'b1;
          state_nxt   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.srch_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.srch_prep = 1'b1;
          state_nxt     = S_START_T;
        end
      end
      S_START_T: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_TRIAL;
        state_nxt     = S_WAIT_T;
      end
      S_WAIT_T: begin
        if (!status.mul_busy) begin
          cmd.srch_upd = 1'b1;
          state_nxt    = S_SEARCH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          cmd.acc_clr   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/cosine_similarity_unit.sv
// Cosine similarity unit: streams element pairs, emits signed Q2.14 similarity.
// Throughput: one pair beat per cycle while accumulating; input stalls after a last pair.
// The time from a last pair to its result is set by the shared shift-add multiplier
// (one bit of multiplier per cycle) and by the output register freeing up.
// The result waits in an output register; new pairs are taken while it waits.
// Synchronous active-low reset clears the accumulators and the controller.
module cosine_similarity_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [csu_pkg::ELEM_W-1:0] in_elem_a,
  input  logic signed [csu_pkg::ELEM_W-1:0] in_elem_b,
  input  logic                              in_last_pair,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [csu_pkg::SIM_W-1:0]  out_similarity,
  output logic                              out_zero_norm
);
  import csu_pkg::*;

  cmd_t    cmd;
  status_t status;

  csu_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_pair (in_last_pair),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status)
  );

  csu_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_elem_a      (in_elem_a),
    .in_elem_b      (in_elem_b),
    .out_similarity (out_similarity),
    .out_zero_norm  (out_zero_norm)
  );

endmodule

### tb/tb_top.sv
// Testbench for the cosine similarity unit: random vector streams checked against a predictor.
`timescale 1ns / 100ps

class sim_scoreboard;
  logic signed [47:0] dot_sum;
  logic [47:0]        norm_a_sum;
  logic [47:0]        norm_b_sum;
  logic [15:0]        exp_sim[$];
  logic               exp_zero[$];
  int                 errors;

  function new();
    dot_sum = '0;
    norm_a_sum = '0;
    norm_b_sum = '0;
    errors = 0;
  endfunction

  // Saturating add into a signed 48-bit accumulator
  function logic signed [47:0] sat_add(logic signed [47:0] acc, logic signed [47:0] inc);
    logic signed [48:0] s;
    s = {acc[47], acc} + {inc[47], inc};
    if (s > 49'sh07FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -49'sh08000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction

  // Largest r in [0,16384] with (2r-1)^2 * Na*Nb <= |dot|^2 * 2^30
  function logic [15:0] cosine_q14();
    logic [47:0]  mag;
    logic [255:0] prod, rhs, lhs;
    int unsigned  lo, hi, mid;
    logic [31:0]  odd;
    mag = dot_sum[47] ? -dot_sum : dot_sum;
    prod = 256'(norm_a_sum) * 256'(norm_b_sum);
    rhs = (256'(mag) * 256'(mag)) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      lhs = prod * 256'(odd) * 256'(odd);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return dot_sum[47] ? -16'(lo) : 16'(lo);
  endfunction

  // Accepted pair beat: accumulate, emit expectation on last pair
  function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    logic signed [31:0] pab, paa, pbb;
    pab = a * b;
    paa = a * a;
    pbb = b * b;
    dot_sum    = sat_add(dot_sum, 48'(pab));
    norm_a_sum = sat_add(norm_a_sum, 48'(paa));
    norm_b_sum = sat_add(norm_b_sum, 48'(pbb));
    if (last) begin
      if (norm_a_sum == 0 || norm_b_sum == 0) begin
        exp_sim.push_back('0);
        exp_zero.push_back(1'b1);
      end else begin
        exp_sim.push_back(cosine_q14());
        exp_zero.push_back(1'b0);
      end
      dot_sum = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
    end
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  // Accepted result beat: compare with oldest expectation
  function void check_result(logic [15:0] sim, logic zero);
    logic [15:0] es;
    logic        ez;
    if (exp_sim.size() == 0) begin
      report($sformatf("unexpected result sim=%0d zero=%0b", $signed(sim), zero));
      return;
    end
    es = exp_sim.pop_front();
    ez = exp_zero.pop_front();
    if (sim !== es) report($sformatf("similarity %0d, expected %0d", $signed(sim), $signed(es)));
    if (zero !== ez) report($sformatf("zero_norm %0b, expected %0b", zero, ez));
  endfunction
endclass

module tb_top;
  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic signed [15:0] in_elem_a, in_elem_b;
  logic in_last_pair;
  logic out_valid, out_stall;
  logic signed [15:0] out_similarity;
  logic out_zero_norm;

  sim_scoreboard sb;
  int  idle_pct_in, idle_pct_out;
  bit  hold_out;
  bit  stim_done;
  bit  hold_done, pause_done;

  cosine_similarity_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_elem_a(in_elem_a), .in_elem_b(in_elem_b), .in_last_pair(in_last_pair),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_similarity(out_similarity), .out_zero_norm(out_zero_norm)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Send one pair beat, with random idle cycles first; valid stays up until the next call
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elem_a <= a;
    in_elem_b <= b;
    in_last_pair <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pair(a, b, last);
  endtask

  function automatic logic signed [15:0] rand_elem(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(512)) - 256);
      2: return ($urandom_range(1)) ? 16'sh7FFF : -16'sh8000;
      default: return 16'sd0;
    endcase
  endfunction

  // One vector of the given length and a random flavor
  task automatic send_vector(int len);
    int mode_a, mode_b, i;
    logic signed [15:0] a, b;
    mode_a = $urandom_range(9) < 7 ? $urandom_range(1) : $urandom_range(3);
    mode_b = $urandom_range(9) < 7 ? $urandom_range(1) : $urandom_range(3);
    for (i = 0; i < len; i++) begin
      a = rand_elem(mode_a);
      b = ($urandom_range(7) == 0) ? a : (($urandom_range(7) == 0) ? -a : rand_elem(mode_b));
      send_pair(a, b, i == len - 1);
    end
  endtask

  // Result side: accept beats, idle by random stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_similarity, out_zero_norm);
    out_stall <= hold_out || ($urandom_range(99) < idle_pct_out);
  end

  initial begin
    int n, k;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_elem_a = 0;
    in_elem_b = 0;
    in_last_pair = 0;
    out_stall = 0;
    hold_out = 0;
    stim_done = 0;
    hold_done = 0;
    pause_done = 0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero norms, identical / opposite, single pair
    send_pair(16'sh7FFF, 16'sh7FFF, 1);
    send_pair(-16'sh8000, 16'sh7FFF, 1);
    send_pair(-16'sh8000, -16'sh8000, 1);
    send_pair(0, 16'sh0100, 1);
    send_pair(16'sh0100, 0, 1);
    send_pair(0, 0, 1);
    send_pair(16'sh0100, 16'sh0100, 0);
    send_pair(16'sh0100, -16'sh0100, 1);
    send_pair(16'sh0100, 0, 0);
    send_pair(0, 16'sh0100, 1);
    send_pair(16'sh0003, 16'sh0004, 0);
    send_pair(16'sh0004, -16'sh0003, 0);
    send_pair(16'sh0001, 16'sh0001, 1);
    send_pair(-16'sh0001, 16'sh7FFF, 0);
    send_pair(16'sh5555, -16'sh2AAB, 1);

    // Random, with idling on both sides except for a stretch with none
    idle_pct_in = 27;
    idle_pct_out = 27;
    n = 15;
    while (n < 1950) begin
      if (n > 600 && n < 900) begin
        idle_pct_in = 0;
        idle_pct_out = 0;
      end else begin
        idle_pct_in = 27;
        idle_pct_out = 27;
      end
      k = ($urandom_range(19) == 0) ? $urandom_range(200, 64) : $urandom_range(16, 1);
      send_vector(k);
      n += k;
      // Receiver holds off while sender keeps offering
      if (n > 1000 && !hold_done) begin
        hold_done = 1;
        hold_out = 1;
        fork
          begin repeat (1500) @(posedge clk); hold_out = 0; end
        join_none
      end
      // Sender pauses until all results are back
      if (n > 1400 && !pause_done) begin
        pause_done = 1;
        in_valid <= 1'b0;
        while (sb.exp_sim.size() != 0) @(posedge clk);
      end
    end
    idle_pct_in = 0;
    in_valid <= 1'b0;
    while (sb.exp_sim.size() != 0 || hold_out) @(posedge clk);
    repeat (700) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

### cosine_similarity_unit.f
rtl/csu_pkg.sv
rtl/csu_dp.sv
rtl/csu_ctrl.sv
rtl/cosine_similarity_unit.sv
tb/tb_top.sv
